// ----- rtl/core/bsr_pkg.sv -----
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types and constants of the bitmap/attribute scanline renderer.
// ----------------------------------------------------------------------------
package bsr_pkg;

   localparam int STORE_BYTES       = 6912;
   localparam int ADDR_W            = 13;
   localparam int ROW_W             = 8;    // store address above the cell column
   localparam int CELL_W            = 5;
   localparam int CELLS_PER_LINE    = 32;
   localparam int LINES             = 192;
   localparam int GROUP_W           = 6;
   localparam int BORDER_PIXELS_DEF = 32;
   localparam int CMDQ_DEPTH        = 4;
   localparam int CMDQ_PTR_W        = 2;
   localparam int CMDQ_CNT_W        = 3;

   // attribute area base (0x1800) as a row of 32 cells
   localparam logic [2:0] ATTR_ROW_TOP = 3'b110;

   typedef enum logic [1:0] {
      OP_WRITE_BYTE  = 2'd0,
      OP_WRITE_PORT  = 2'd1,
      OP_START_FRAME = 2'd2,
      OP_RENDER_LINE = 2'd3
   } op_type;

   // render: addr holds the bitmap row base, data the attribute row
   typedef struct packed {
      op_type            op;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } cmd_type;

endpackage

// ----- rtl/core/bsr_front.sv -----
// ----------------------------------------------------------------------------
// bsr_front
// Takes input items, drops the ones that change nothing, queues the rest.
// ----------------------------------------------------------------------------
module bsr_front (
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [47:0]      req_tdata,
   input  logic [1:0]       req_tuser,
   input  logic             q_full,
   input  logic             clear_busy,
   output logic             q_push,
   output bsr_pkg::cmd_type q_cmd
);
   import bsr_pkg::*;

   logic [ADDR_W-1:0] offset;
   logic [7:0]        value;
   logic [15:0]       port;
   logic [7:0]        line;
   op_type            op;
   logic              keep;

   assign offset = req_tdata[12:0];
   assign value  = req_tdata[20:13];
   assign port   = req_tdata[36:21];
   assign line   = req_tdata[44:37];
   assign op     = op_type'(req_tuser);

   always_comb begin
      keep       = 1'b0;
      q_cmd.op   = op;
      q_cmd.addr = offset;
      q_cmd.data = value;
      case (op)
         OP_WRITE_BYTE: begin
            keep = (offset < ADDR_W'(STORE_BYTES));
         end
         OP_WRITE_PORT: begin
            keep = ~port[0];
         end
         OP_START_FRAME: begin
            keep = 1'b1;
         end
         OP_RENDER_LINE: begin
            keep       = (line < 8'(LINES));
            // interleaved bitmap row: y7 y6 y2 y1 y0 y5 y4 y3
            q_cmd.addr = {line[7:6], line[2:0], line[5:3], {CELL_W{1'b0}}};
            q_cmd.data = {ATTR_ROW_TOP, line[7:3]};
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_tready = ~q_full & ~clear_busy;
   assign q_push     = req_tvalid & req_tready & keep;

endmodule

// ----- rtl/core/bsr_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// bsr_cmd_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module bsr_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bsr_pkg::cmd_type cmd_in,
   input  logic             pop,
   output bsr_pkg::cmd_type cmd_out,
   output logic             full,
   output logic             empty
);
   import bsr_pkg::*;

   cmd_type                 entry_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign full    = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign cmd_out = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// ----- rtl/core/bsr_back.sv -----
// ----------------------------------------------------------------------------
// bsr_back
// Executes queued commands: screen store, border, flash and line rendering.
// ----------------------------------------------------------------------------
module bsr_back #(
   parameter int BORDER_PIXELS = bsr_pkg::BORDER_PIXELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  bsr_pkg::cmd_type             q_cmd,
   output logic                         q_pop,
   output logic                         clear_busy,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [31:0]                  rsp_pixels,
   output logic [bsr_pkg::GROUP_W-1:0]  rsp_index,
   output logic                         rsp_last
);
   import bsr_pkg::*;

   localparam int BORDER_GROUPS = BORDER_PIXELS / 8;
   localparam int TOTAL_GROUPS  = 2 * BORDER_GROUPS + CELLS_PER_LINE;
   localparam int CELL_END      = BORDER_GROUPS + CELLS_PER_LINE;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_RUN    = 3'b010,
      ST_RENDER = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic [2:0]            border_ff, border_in;
   logic [4:0]            flash_ff, flash_in;
   logic [ROW_W-1:0]      pix_row_ff, pix_row_in;
   logic [ROW_W-1:0]      attr_row_ff, attr_row_in;
   logic [2:0]            rnd_border_ff, rnd_border_in;
   logic                  rnd_flash_ff, rnd_flash_in;
   logic [GROUP_W-1:0]    grp_ff, grp_in;

   // issue stage -> compute stage
   logic                  s1_vld_ff, s1_vld_in;
   logic [GROUP_W-1:0]    s1_grp_ff, s1_grp_in;
   logic                  s1_cell_ff, s1_cell_in;

   // output register
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [31:0]           rsp_pix_ff, rsp_pix_in;
   logic [GROUP_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic                  rsp_last_ff, rsp_last_in;

   // screen store
   logic [7:0]            screen_mem [STORE_BYTES];
   logic [7:0]            bits_rd_ff, attr_rd_ff;
   logic                  mem_we, mem_re;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [7:0]            mem_wdata;
   logic [CELL_W-1:0]     cell_col;
   logic [GROUP_W-1:0]    cell_rel;
   logic                  issue_cell;

   logic                  advance;
   logic [3:0]            ink, paper;
   logic [31:0]           cell_pix;

   assign advance    = ~rsp_vld_ff | rsp_ready;
   assign cell_rel   = grp_ff - GROUP_W'(BORDER_GROUPS);
   assign cell_col   = cell_rel[CELL_W-1:0];
   assign issue_cell = (grp_ff >= GROUP_W'(BORDER_GROUPS)) && (grp_ff < GROUP_W'(CELL_END));
   // hold the next command while a group of the previous line is stuck in s1
   assign q_pop      = (state_ff == ST_RUN) & ~q_empty & (~s1_vld_ff | advance);
   assign clear_busy = (state_ff == ST_CLEAR);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      border_in     = border_ff;
      flash_in      = flash_ff;
      pix_row_in    = pix_row_ff;
      attr_row_in   = attr_row_ff;
      rnd_border_in = rnd_border_ff;
      rnd_flash_in  = rnd_flash_ff;
      grp_in        = grp_ff;
      s1_vld_in     = s1_vld_ff;
      s1_grp_in     = s1_grp_ff;
      s1_cell_in    = s1_cell_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = q_cmd.addr;
      mem_wdata     = q_cmd.data;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
            if (clr_addr_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = ST_RUN;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
            if (advance) begin
               s1_vld_in = 1'b0;
            end
         end
         ST_RUN: begin
            if (advance) begin
               s1_vld_in = 1'b0;
            end
            if (q_pop) begin
               case (q_cmd.op)
                  OP_WRITE_BYTE: begin
                     mem_we = 1'b1;
                  end
                  OP_WRITE_PORT: begin
                     border_in = q_cmd.data[2:0];
                  end
                  OP_START_FRAME: begin
                     flash_in = flash_ff + 1'b1;
                  end
                  OP_RENDER_LINE: begin
                     pix_row_in    = q_cmd.addr[ADDR_W-1:CELL_W];
                     attr_row_in   = q_cmd.data;
                     rnd_border_in = border_ff;
                     rnd_flash_in  = ~flash_ff[4];   // counter below 16
                     grp_in        = '0;
                     state_in      = ST_RENDER;
                  end
                  default: begin
                     state_in = ST_RUN;
                  end
               endcase
            end
         end
         ST_RENDER: begin
            if (advance) begin
               mem_re     = issue_cell;
               s1_vld_in  = 1'b1;
               s1_grp_in  = grp_ff;
               s1_cell_in = issue_cell;
               grp_in     = grp_ff + 1'b1;
               if (grp_ff == GROUP_W'(TOTAL_GROUPS - 1)) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // attribute decode and pixel expansion
   always_comb begin
      ink   = {attr_rd_ff[6], attr_rd_ff[2:0]};
      paper = attr_rd_ff[6:3];
      if (attr_rd_ff[7] && rnd_flash_ff) begin
         ink   = attr_rd_ff[6:3];
         paper = {attr_rd_ff[6], attr_rd_ff[2:0]};
      end
      for (int i = 0; i < 8; i++) begin
         cell_pix[4*i +: 4] = bits_rd_ff[i] ? ink : paper;
      end
   end

   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_pix_in  = rsp_pix_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_last_in = rsp_last_ff;
      if (advance) begin
         rsp_vld_in  = s1_vld_ff;
         rsp_pix_in  = s1_cell_ff ? cell_pix : {8{1'b0, rnd_border_ff}};
         rsp_idx_in  = s1_grp_ff;
         rsp_last_in = (s1_grp_ff == GROUP_W'(TOTAL_GROUPS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         border_ff   <= '0;
         flash_ff    <= '0;
         s1_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         border_ff   <= border_in;
         flash_ff    <= flash_in;
         s1_vld_ff   <= s1_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_row_ff    <= pix_row_in;
      attr_row_ff   <= attr_row_in;
      rnd_border_ff <= rnd_border_in;
      rnd_flash_ff  <= rnd_flash_in;
      grp_ff        <= grp_in;
      s1_grp_ff     <= s1_grp_in;
      s1_cell_ff    <= s1_cell_in;
      rsp_pix_ff    <= rsp_pix_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         bits_rd_ff <= screen_mem[{pix_row_ff, cell_col}];
         attr_rd_ff <= screen_mem[{attr_row_ff, cell_col}];
      end
   end

   assign rsp_valid  = rsp_vld_ff;
   assign rsp_pixels = rsp_pix_ff;
   assign rsp_index  = rsp_idx_ff;
   assign rsp_last   = rsp_last_ff;

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("store read and write in the same cycle");

   a_pop_when_run: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_RUN) && (!s1_vld_ff || advance))
      else $error("command popped outside run state");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ready && !rsp_last_ff) |=>
         (!rsp_vld_ff || rsp_idx_ff == GROUP_W'($past(rsp_idx_ff) + 1'b1)))
      else $error("group index skipped within a line");

   a_no_output_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !s1_vld_ff && !mem_re)
      else $error("render activity during clearing pass");

endmodule

// ----- rtl/core/bitmap_attribute_scanline_renderer.sv -----
// ----------------------------------------------------------------------------
// bitmap_attribute_scanline_renderer
// Screen store with bitmap and attributes, border and flash; renders lines.
// ----------------------------------------------------------------------------
// After reset the block zeroes the screen store, one byte per cycle, with
// req_tready low. Then each item is one command: a screen byte write, a port
// write (even port sets the border), a frame start (flash counter +1 mod 32)
// or a line render. Writes, port writes and frame starts give no output. A
// render of a line below 192 gives 2*(BORDER_PIXELS/8)+32 groups (40 by
// default) at one group per cycle when rsp_tready stays high, each passing
// the issue stage, s1 and the output register; the rate is set by the group
// sequencer, which reads the bitmap and attribute bytes of one cell per
// cycle from the store's two read ports. A four-entry command queue sits
// between the input and the engine, so items keep being taken while a line
// is drained, until the queue fills. Commands that change nothing (offset
// past the store, odd port, line 192 and up) are dropped on entry.
// rsp_tlast marks the final group of a line.
// ----------------------------------------------------------------------------
module bitmap_attribute_scanline_renderer #(
   parameter int BORDER_PIXELS = bsr_pkg::BORDER_PIXELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // mem_offset[12:0], value[20:13], port[36:21], line[44:37]
   input  logic [1:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // pixels[31:0], group_index[37:32], zero pad
   output logic        rsp_tlast    // last
);
   import bsr_pkg::*;

   cmd_type            push_cmd, head_cmd;
   logic               q_push, q_pop, q_full, q_empty, clear_busy;
   logic [31:0]        pixels;
   logic [GROUP_W-1:0] group_index;

   bsr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .clear_busy (clear_busy),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   bsr_cmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .cmd_in  (push_cmd),
      .pop     (q_pop),
      .cmd_out (head_cmd),
      .full    (q_full),
      .empty   (q_empty)
   );

   bsr_back #(
      .BORDER_PIXELS (BORDER_PIXELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .clear_busy (clear_busy),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_pixels (pixels),
      .rsp_index  (group_index),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, group_index, pixels};

endmodule

// ----- tb/bitmap_attribute_scanline_renderer_tb.sv -----
// ----------------------------------------------------------------------------
// bitmap_attribute_scanline_renderer_tb
// Self-checking bench for the scanline renderer: screen and port writes,
// frame starts and line renders go in, and every pixel group that comes out
// is checked against a predictor that keeps its own screen store, border
// color and flash count.
// ----------------------------------------------------------------------------
module bitmap_attribute_scanline_renderer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bsr_pkg::*;

   localparam int     BORDER_PIXELS     = BORDER_PIXELS_DEF;
   localparam int     BORDER_GROUPS     = BORDER_PIXELS / 8;
   localparam int     CLK_HALF_NS       = 10;
   localparam int     RESET_CYCLES      = 6;
   localparam int     ITEMS_PER_PHASE   = 64;
   localparam int     DRAIN_CYCLES      = 50;      // linger after the drain so stray groups get caught
   localparam int     FLASH_SWAP_BELOW  = 16;
   localparam longint TIMEOUT_NS        = 64'd8_000_000;

   // One eight-pixel group as seen on the result channel.
   typedef struct {
      logic [31:0] pixels;
      logic [5:0]  grp;
      logic        last;
   } pixel_group;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts the groups of each accepted render and checks them
   // in order against what the block produces.
   // -------------------------------------------------------------------------
   class scanline_scoreboard;
      logic [7:0] screen_mem [STORE_BYTES];
      logic [2:0] border_colour;
      logic [4:0] flash_count;
      int         border_groups;
      int         errors;
      pixel_group groups_due[$];

      function new(int border_groups_in);
         border_groups = border_groups_in;
         foreach (screen_mem[i]) screen_mem[i] = 8'h00;
         border_colour = '0;
         flash_count   = '0;
         errors        = 0;
      endfunction

      // interleaved bitmap row: y7y6 y2y1y0 y5y4y3 then the cell column
      static function logic [12:0] bitmap_row(logic [7:0] line);
         return {line[7:6], line[2:0], line[5:3], 5'b00000};
      endfunction

      static function logic [12:0] attr_row(logic [7:0] line);
         return {ATTR_ROW_TOP, 10'd0} + {line[7:3], 5'b00000};
      endfunction

      function void note_command(op_type op, logic [12:0] offset, logic [7:0] value,
                                 logic [15:0] port, logic [7:0] line);
         logic [12:0] bits_addr;
         logic [12:0] attr_addr;
         logic [7:0]  bits;
         logic [7:0]  attr;
         logic [3:0]  ink;
         logic [3:0]  paper;
         logic [31:0] border_px;
         logic [31:0] cell_px;
         pixel_group  g;
         int          total;
         total = 2 * border_groups + CELLS_PER_LINE;
         case (op)
            OP_WRITE_BYTE: begin
               if (offset < STORE_BYTES) screen_mem[offset] = value;
            end
            OP_WRITE_PORT: begin
               if (!port[0]) border_colour = value[2:0];
            end
            OP_START_FRAME: begin
               flash_count = flash_count + 5'd1;   // wraps at 32
            end
            OP_RENDER_LINE: begin
               if (line < LINES) begin
                  border_px = {8{{1'b0, border_colour}}};
                  bits_addr = bitmap_row(line);
                  attr_addr = attr_row(line);
                  for (int k = 0; k < total; k++) begin
                     if (k < border_groups || k >= border_groups + CELLS_PER_LINE) begin
                        g.pixels = border_px;
                     end else begin
                        bits  = screen_mem[bits_addr + k - border_groups];
                        attr  = screen_mem[attr_addr + k - border_groups];
                        ink   = {attr[6], attr[2:0]};
                        paper = attr[6:3];
                        if (attr[7] && flash_count < FLASH_SWAP_BELOW) {ink, paper} = {paper, ink};
                        cell_px = '0;
                        for (int b = 7; b >= 0; b--) cell_px = {cell_px[27:0], bits[b] ? ink : paper};
                        g.pixels = cell_px;
                     end
                     g.grp  = k[5:0];
                     g.last = (k == total - 1);
                     groups_due.push_back(g);
                  end
               end
            end
         endcase
      endfunction

      function void check_group(logic [31:0] pixels, logic [5:0] grp, logic last);
         pixel_group want;
         if (groups_due.size() == 0) begin
            $display("%0t: unexpected group: pixels %h index %0d last %b", $time, pixels, grp, last);
            errors++;
            return;
         end
         want = groups_due.pop_front();
         if (pixels !== want.pixels) begin
            $display("%0t: pixels: expected %h, actual %h", $time, want.pixels, pixels);
            errors++;
         end
         if (grp !== want.grp) begin
            $display("%0t: group index: expected %0d, actual %0d", $time, want.grp, grp);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last: expected %b, actual %b", $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block hookup. Every input has a known value from time zero.
   // -------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;     // mem_offset, value, port, line, zero pad
   logic [1:0]  req_tuser  = '0;     // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // pixels, group_index, zero pad
   logic        rsp_tlast;

   bitmap_attribute_scanline_renderer #(
      .BORDER_PIXELS(BORDER_PIXELS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   scanline_scoreboard sb;
   int                 send_idle_pct = 18;
   int                 recv_idle_pct = 78;
   logic [7:0]         focus_line    = 8'd0;   // line the random writes are building up

   initial begin
      forever #(CLK_HALF_NS) clock = ~clock;
   end

   // Receiver: stalls at random at the current rate, one draw per cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Result monitor: values sampled at the edge are the ones settled before it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_group(rsp_tdata[31:0], rsp_tdata[37:32], rsp_tlast);
      end
   end

   // Sends one item, with a random gap ahead of it at the current idle rate.
   // tvalid is only lowered inside a gap, so back-to-back items keep it high.
   task automatic send_item(input op_type op, input logic [12:0] offset,
                            input logic [7:0] value, input logic [15:0] port,
                            input logic [7:0] line);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, line, port, value, offset};
      do @(posedge clock); while (!req_tready);
      sb.note_command(op, offset, value, port, line);
   endtask

   // Random item. Most writes land in the bitmap or attribute row of the
   // focus line and most renders hit that line, so renders show real content.
   // Unused fields always carry noise.
   task automatic send_random_item();
      int          pick;
      int          col;
      logic [12:0] offset;
      logic [7:0]  line;
      pick = $urandom_range(0, 99);
      col  = $urandom_range(0, CELLS_PER_LINE - 1);
      if (pick < 40) begin
         case ($urandom_range(0, 4))
            0, 1:    offset = 13'(scanline_scoreboard::bitmap_row(focus_line) + col);
            2, 3:    offset = 13'(scanline_scoreboard::attr_row(focus_line) + col);
            default: offset = 13'($urandom_range(0, 8191));   // includes past-the-end
         endcase
         send_item(OP_WRITE_BYTE, offset, 8'($urandom), 16'($urandom), 8'($urandom));
      end else if (pick < 50) begin
         send_item(OP_WRITE_PORT, 13'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
      end else if (pick < 72) begin
         send_item(OP_START_FRAME, 13'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
      end else begin
         // a few renders anywhere in 0..255, the high ones are dropped
         line = ($urandom_range(0, 9) == 0) ? 8'($urandom) : focus_line;
         send_item(OP_RENDER_LINE, 13'($urandom), 8'($urandom), 16'($urandom), line);
         focus_line = 8'($urandom_range(0, LINES - 1));
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      sb = new(BORDER_GROUPS);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // The store clear after reset holds req_tready low; send_item just waits.

      // Directed: first and last cells, both store ends, flash and plain
      // attributes, writes past the store, odd and even ports, line bounds.
      send_item(OP_WRITE_BYTE, 13'h0000, 8'hFF, 16'h0000, 8'h00);
      send_item(OP_WRITE_BYTE, 13'h0001, 8'hA5, 16'hFFFF, 8'hFF);
      send_item(OP_WRITE_BYTE, 13'h1800, 8'hC7, 16'h0000, 8'h00);   // flashing bright
      send_item(OP_WRITE_BYTE, 13'h1801, 8'h3A, 16'h0000, 8'h00);
      send_item(OP_WRITE_BYTE, 13'h17FF, 8'h81, 16'h0000, 8'h00);   // line 191, last cell
      send_item(OP_WRITE_BYTE, 13'(STORE_BYTES - 1), 8'hFF, 16'h0000, 8'h00);
      send_item(OP_WRITE_BYTE, 13'(STORE_BYTES), 8'h55, 16'h0000, 8'h00);  // ignored
      send_item(OP_WRITE_BYTE, 13'h1FFF, 8'hAA, 16'h0000, 8'h00);          // ignored
      send_item(OP_WRITE_PORT, 13'h1FFF, 8'hFF, 16'hFFFE, 8'hFF);   // border 7
      send_item(OP_WRITE_PORT, 13'h0000, 8'h02, 16'hFFFF, 8'h00);   // odd: no change
      send_item(OP_RENDER_LINE, 13'h0000, 8'h00, 16'h0000, 8'd0);
      send_item(OP_RENDER_LINE, 13'h1FFF, 8'hFF, 16'hFFFF, 8'd191);
      send_item(OP_RENDER_LINE, 13'h0000, 8'h00, 16'h0000, 8'd192);  // dropped
      send_item(OP_RENDER_LINE, 13'h0000, 8'h00, 16'h0000, 8'd255);  // dropped
      send_item(OP_START_FRAME, 13'h0000, 8'h00, 16'h0000, 8'h00);
      send_item(OP_WRITE_PORT, 13'h0000, 8'hFA, 16'h0000, 8'h00);   // border 2
      send_item(OP_RENDER_LINE, 13'h0000, 8'h00, 16'h0000, 8'd0);

      // Random: busy sender/frequent stalls, then the reverse, then full speed.
      // ~22% frame starts carry the flash count through 16 and past its wrap.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 18; recv_idle_pct = 78; end
            1:       begin send_idle_pct = 78; recv_idle_pct = 18; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         repeat (ITEMS_PER_PHASE) send_random_item();
      end
      req_tvalid <= 1'b0;

      // Drain, then linger so any stray extra group gets caught.
      while (sb.groups_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.groups_due.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   // Watchdog: well past the slowest correct run, store clear included.
   initial begin
      #(TIMEOUT_NS);
      $display("FAIL");
      $finish;
   end

endmodule
